>>> rtl/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mpid_pkg.sv
// types and constants of the position pid controller
package mpid_pkg;

	localparam int OPA_W  = 33;
	localparam int OPB_W  = 17;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int ACC_W  = 68;

	typedef enum logic [2:0] {
		REG_GAIN_P  = 3'd0,
		REG_GAIN_I  = 3'd1,
		REG_GAIN_D  = 3'd2,
		REG_STALL_V = 3'd3,
		REG_ADAPT   = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [11:0] stall_v;
		logic [11:0] adapt;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic add;
		logic sub;
		logic sh16;
		logic mul;
	} mac_ctl_t;

	localparam logic [11:0] STALL_V_RESET = 12'd1024;
	localparam logic [11:0] DITHER_MIN_V  = 12'd50;
	localparam logic [40:0] OVER_CAP      = 41'h100_0000_0000;

endpackage

>>> rtl/mpid_mac.sv
// shared multiplier with product register and accumulator
module mpid_mac (
	input  logic                                    clk,
	input  mpid_pkg::mac_ctl_t                      ctl,
	input  logic signed [mpid_pkg::OPA_W-1:0]       op_a,
	input  logic signed [mpid_pkg::OPB_W-1:0]       op_b,
	input  logic signed [31:0]                      load_val,
	output logic signed [mpid_pkg::ACC_W-1:0]       acc
);

	logic signed [mpid_pkg::PROD_W-1:0] prod_q;
	logic                               sh_q;
	logic signed [mpid_pkg::ACC_W-1:0]  acc_q;
	logic signed [mpid_pkg::ACC_W-1:0]  prod_ext;
	logic signed [mpid_pkg::ACC_W-1:0]  addend;

	assign prod_ext = sh_q ? (mpid_pkg::ACC_W'(prod_q) <<< 16) : mpid_pkg::ACC_W'(prod_q);
	assign addend   = ctl.sub ? -prod_ext : prod_ext;
	assign acc      = acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_q <= op_a * op_b;
			sh_q   <= ctl.sh16;
		end
		if (ctl.load) begin
			acc_q <= mpid_pkg::ACC_W'(load_val);
		end else if (ctl.add) begin
			acc_q <= acc_q + addend;
		end
	end

endmodule

>>> rtl/mpid_seq.sv
// tick sequencer: step rounding, integrator, dither, torque and stall logic
module mpid_seq #(
	parameter int QUARTER_TURN = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mpid_pkg::cfg_t                      cfg,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                synced,
	input  logic signed [23:0]                  count_delta,
	input  logic signed [31:0]                  pos_error,
	input  logic signed [15:0]                  lead_in,
	input  logic signed [31:0]                  velocity_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                active,
	output logic signed [15:0]                  armature_steps,
	output logic [11:0]                         drive_voltage,
	output logic signed [15:0]                  lead_out,
	output logic signed [31:0]                  velocity_out,
	output logic signed [1:0]                   counter_nudge,
	output logic                                voltage_limited,
	output logic                                stalled,
	output mpid_pkg::mac_ctl_t                  mac_ctl,
	output logic signed [mpid_pkg::OPA_W-1:0]   op_a,
	output logic signed [mpid_pkg::OPB_W-1:0]   op_b,
	output logic signed [31:0]                  load_val,
	input  logic signed [mpid_pkg::ACC_W-1:0]   acc
);

	localparam logic [15:0] QT = 16'(QUARTER_TURN);

	typedef enum logic [3:0] {
		ST_IDLE, ST_PREP, ST_MUL_P, ST_MUL_D, ST_MUL_IL, ST_MUL_IH, ST_ACC_I,
		ST_TORQ, ST_LIMIT, ST_MUL_OL, ST_MUL_OH, ST_ACC_V, ST_DONE
	} state_t;

	state_t             state_q;
	logic               unsync_q;
	logic signed [23:0] cnt_q;
	logic signed [31:0] err_q;
	logic signed [32:0] deriv_q;
	logic [15:0]        lead_q;
	logic signed [31:0] vel_q;
	logic signed [15:0] steps_q;
	logic signed [1:0]  nudge_q;
	logic signed [51:0] torque_q;
	logic [40:0]        over_q;
	logic               tneg_q;
	logic               limited_q;
	logic [11:0]        drive_q;

	logic signed [31:0] cf_q;
	logic signed [47:0] esum_q;
	logic signed [31:0] last_err_q;
	logic               phase_q;
	logic [11:0]        last_v_q;

	logic               out_valid_q;
	logic               active_q;
	logic signed [15:0] steps_out_q;
	logic [11:0]        drive_out_q;
	logic [15:0]        lead_out_q;
	logic signed [31:0] vel_out_q;
	logic signed [1:0]  nudge_out_q;
	logic               limited_out_q;
	logic               stalled_q;

	// step rounding
	logic signed [32:0] s_c;
	logic [32:0]        s_abs;
	logic [33:0]        s_rnd;
	logic [25:0]        q_mag;
	logic [25:0]        q_lim;
	logic [25:0]        q_sat;
	logic signed [16:0] steps_c;
	logic signed [33:0] cf_w;
	// integrator and derivative
	logic signed [48:0] es_w;
	logic signed [47:0] esum_c;
	logic signed [32:0] deriv_c;
	logic               dither_on;
	// torque and limit
	logic signed [51:0] torque_c;
	logic [51:0]        mag_c;
	logic signed [52:0] over_w;
	logic               lim_c;
	logic [40:0]        over_c;
	// velocity
	logic signed [31:0] vel_sat;
	logic               stall_c;
	logic               out_free;

	assign s_c     = 33'(cf_q) + 33'(cnt_q);
	assign s_abs   = s_c[32] ? 33'(-s_c) : 33'(s_c);
	assign s_rnd   = 34'(s_abs) + 34'd128;
	assign q_mag   = s_rnd[33:8];
	assign q_lim   = s_c[32] ? 26'd32768 : 26'd32767;
	assign q_sat   = (q_mag > q_lim) ? q_lim : q_mag;
	assign steps_c = s_c[32] ? -$signed(q_sat[16:0]) : $signed(q_sat[16:0]);
	assign cf_w    = 34'(s_c) - (34'(steps_c) <<< 8);

	assign es_w    = 49'(esum_q) + 49'(err_q);
	assign esum_c  = (es_w[48] != es_w[47]) ?
		(es_w[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : es_w[47:0];
	assign deriv_c = 33'(err_q) - 33'(last_err_q);
	assign dither_on = (cfg.adapt != 12'd0) && (last_v_q > mpid_pkg::DITHER_MIN_V);

	assign torque_c = $signed(acc[67:16]) + 52'(acc[67] && (acc[15:0] != 16'd0));
	assign mag_c    = torque_q[51] ? 52'(-torque_q) : 52'(torque_q);
	assign over_w   = $signed({1'b0, mag_c}) - $signed({41'b0, cfg.stall_v});
	assign lim_c    = !over_w[52] && (over_w != 53'sd0);
	assign over_c   = !lim_c ? 41'd0 :
		((over_w[51:0] > 52'(mpid_pkg::OVER_CAP)) ? mpid_pkg::OVER_CAP : over_w[40:0]);

	assign vel_sat = (acc > 68'sd2147483647) ? 32'sh7FFF_FFFF :
		((acc < -68'sd2147483648) ? 32'sh8000_0000 : acc[31:0]);
	assign stall_c  = limited_q && (tneg_q ? (acc > 68'sd0) : acc[67]);
	assign out_free = !out_valid_q || !out_stall;

	// shared unit schedule
	always_comb begin
		mac_ctl  = '0;
		op_a     = '0;
		op_b     = '0;
		load_val = (state_q == ST_LIMIT) ? vel_q : 32'sd0;
		unique case (state_q)
			ST_PREP: begin
				mac_ctl.load = 1'b1;
			end
			ST_MUL_P: begin
				mac_ctl.mul = 1'b1;
				op_a = 33'(err_q);
				op_b = $signed({1'b0, cfg.gain_p});
			end
			ST_MUL_D: begin
				mac_ctl.add = 1'b1;
				mac_ctl.mul = 1'b1;
				op_a = deriv_q;
				op_b = $signed({1'b0, cfg.gain_d});
			end
			ST_MUL_IL: begin
				mac_ctl.add = 1'b1;
				mac_ctl.mul = 1'b1;
				op_a = $signed({17'b0, esum_q[15:0]});
				op_b = $signed({1'b0, cfg.gain_i});
			end
			ST_MUL_IH: begin
				mac_ctl.add  = 1'b1;
				mac_ctl.mul  = 1'b1;
				mac_ctl.sh16 = 1'b1;
				op_a = 33'($signed(esum_q[47:16]));
				op_b = $signed({1'b0, cfg.gain_i});
			end
			ST_ACC_I: begin
				mac_ctl.add = 1'b1;
			end
			ST_LIMIT: begin
				mac_ctl.load = 1'b1;
			end
			ST_MUL_OL: begin
				mac_ctl.mul = 1'b1;
				op_a = $signed({17'b0, over_q[15:0]});
				op_b = $signed({1'b0, cfg.gain_i});
			end
			ST_MUL_OH: begin
				mac_ctl.add  = 1'b1;
				mac_ctl.sub  = !tneg_q;
				mac_ctl.mul  = 1'b1;
				mac_ctl.sh16 = 1'b1;
				op_a = $signed({8'b0, over_q[40:16]});
				op_b = $signed({1'b0, cfg.gain_i});
			end
			ST_ACC_V: begin
				mac_ctl.add = 1'b1;
				mac_ctl.sub = !tneg_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			unsync_q      <= 1'b0;
			cnt_q         <= '0;
			err_q         <= '0;
			deriv_q       <= '0;
			lead_q        <= '0;
			vel_q         <= '0;
			steps_q       <= '0;
			nudge_q       <= '0;
			torque_q      <= '0;
			over_q        <= '0;
			tneg_q        <= 1'b0;
			limited_q     <= 1'b0;
			drive_q       <= '0;
			cf_q          <= '0;
			esum_q        <= '0;
			last_err_q    <= '0;
			phase_q       <= 1'b0;
			last_v_q      <= '0;
			out_valid_q   <= 1'b0;
			active_q      <= 1'b0;
			steps_out_q   <= '0;
			drive_out_q   <= '0;
			lead_out_q    <= '0;
			vel_out_q     <= '0;
			nudge_out_q   <= '0;
			limited_out_q <= 1'b0;
			stalled_q     <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unsync_q <= !synced;
						cnt_q    <= count_delta;
						err_q    <= pos_error;
						lead_q   <= lead_in;
						vel_q    <= velocity_in;
						state_q  <= synced ? ST_PREP : ST_DONE;
					end
				end
				ST_PREP: begin
					steps_q <= (cnt_q != 24'sd0) ? steps_c[15:0] : 16'sd0;
					if (cnt_q != 24'sd0) begin
						cf_q <= cf_w[31:0];
					end
					esum_q     <= esum_c;
					deriv_q    <= deriv_c;
					last_err_q <= err_q;
					if (dither_on && phase_q && (deriv_c > 33'sd0)) begin
						nudge_q <= -2'sd1;
					end else if (dither_on && phase_q && (deriv_c < 33'sd0)) begin
						nudge_q <= 2'sd1;
					end else begin
						nudge_q <= '0;
					end
					if (dither_on) begin
						phase_q <= !phase_q;
						if (phase_q) begin
							lead_q <= lead_q - 16'(cfg.adapt);
						end else begin
							lead_q <= lead_q + 16'(cfg.adapt);
						end
					end
					state_q <= ST_MUL_P;
				end
				ST_MUL_P:  state_q <= ST_MUL_D;
				ST_MUL_D:  state_q <= ST_MUL_IL;
				ST_MUL_IL: state_q <= ST_MUL_IH;
				ST_MUL_IH: state_q <= ST_ACC_I;
				ST_ACC_I:  state_q <= ST_TORQ;
				ST_TORQ: begin
					torque_q <= torque_c;
					state_q  <= ST_LIMIT;
				end
				ST_LIMIT: begin
					tneg_q    <= torque_q[51];
					limited_q <= lim_c;
					over_q    <= over_c;
					drive_q   <= lim_c ? cfg.stall_v : mag_c[11:0];
					last_v_q  <= lim_c ? cfg.stall_v : mag_c[11:0];
					lead_q    <= torque_q[51] ? (lead_q - QT) : (lead_q + QT);
					state_q   <= ST_MUL_OL;
				end
				ST_MUL_OL: state_q <= ST_MUL_OH;
				ST_MUL_OH: state_q <= ST_ACC_V;
				ST_ACC_V:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						lead_out_q  <= lead_q;
						if (unsync_q) begin
							active_q      <= 1'b0;
							steps_out_q   <= '0;
							drive_out_q   <= last_v_q;
							vel_out_q     <= vel_q;
							nudge_out_q   <= '0;
							limited_out_q <= 1'b0;
							stalled_q     <= 1'b0;
						end else begin
							active_q      <= !stall_c;
							steps_out_q   <= steps_q;
							drive_out_q   <= drive_q;
							vel_out_q     <= vel_sat;
							nudge_out_q   <= nudge_q;
							limited_out_q <= limited_q;
							stalled_q     <= stall_c;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall        = !arst_n || (state_q != ST_IDLE);
	assign out_valid       = out_valid_q;
	assign active          = active_q;
	assign armature_steps  = steps_out_q;
	assign drive_voltage   = drive_out_q;
	assign lead_out        = lead_out_q;
	assign velocity_out    = vel_out_q;
	assign counter_nudge   = nudge_out_q;
	assign voltage_limited = limited_out_q;
	assign stalled         = stalled_q;

endmodule

>>> rtl/motor_position_pid_with_stall_detect.sv
// position pid controller with lead-angle dither and stall detection
//
// one control tick is a transfer on the input channel (in_valid, in_stall);
// its single result is a transfer on the output channel (out_valid, out_stall).
// a synced tick makes six passes through the shared 33x17 multiply-accumulate
// unit; the next tick is taken only once the result is in the output register.
// an unsynced tick goes straight to the result and leaves all state untouched.
// in_stall is high from the input transfer until the result is loaded into
// the output register; a stalled result holds there while the next tick
// is already accepted and worked on, and that one waits until it is taken.
// registers are written through wr_en / wr_index / wr_data; the user must
// write them only while idle, which the block itself does not enforce.
// reset clears the fraction, integrator, last error, dither phase and last
// voltage, sets stall_voltage to 1024 and all other registers to zero.
// in_stall is held high while reset is asserted.
module motor_position_pid_with_stall_detect #(
	parameter int QUARTER_TURN = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [15:0]        wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               synced,
	input  logic signed [23:0] count_delta,
	input  logic signed [31:0] pos_error,
	input  logic signed [15:0] lead_in,
	input  logic signed [31:0] velocity_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               active,
	output logic signed [15:0] armature_steps,
	output logic [11:0]        drive_voltage,
	output logic signed [15:0] lead_out,
	output logic signed [31:0] velocity_out,
	output logic signed [1:0]  counter_nudge,
	output logic               voltage_limited,
	output logic               stalled
);

	mpid_pkg::cfg_t                           cfg_q;
	mpid_pkg::mac_ctl_t                       mac_ctl;
	logic signed [mpid_pkg::OPA_W-1:0]        op_a;
	logic signed [mpid_pkg::OPB_W-1:0]        op_b;
	logic signed [31:0]                       load_val;
	logic signed [mpid_pkg::ACC_W-1:0]        acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p  <= '0;
			cfg_q.gain_i  <= '0;
			cfg_q.gain_d  <= '0;
			cfg_q.stall_v <= mpid_pkg::STALL_V_RESET;
			cfg_q.adapt   <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				mpid_pkg::REG_GAIN_P:  cfg_q.gain_p  <= wr_data;
				mpid_pkg::REG_GAIN_I:  cfg_q.gain_i  <= wr_data;
				mpid_pkg::REG_GAIN_D:  cfg_q.gain_d  <= wr_data;
				mpid_pkg::REG_STALL_V: cfg_q.stall_v <= wr_data[11:0];
				mpid_pkg::REG_ADAPT:   cfg_q.adapt   <= wr_data[11:0];
				default: begin
				end
			endcase
		end
	end

	mpid_seq #(
		.QUARTER_TURN (QUARTER_TURN)
	) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.synced          (synced),
		.count_delta     (count_delta),
		.pos_error       (pos_error),
		.lead_in         (lead_in),
		.velocity_in     (velocity_in),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.active          (active),
		.armature_steps  (armature_steps),
		.drive_voltage   (drive_voltage),
		.lead_out        (lead_out),
		.velocity_out    (velocity_out),
		.counter_nudge   (counter_nudge),
		.voltage_limited (voltage_limited),
		.stalled         (stalled),
		.mac_ctl         (mac_ctl),
		.op_a            (op_a),
		.op_b            (op_b),
		.load_val        (load_val),
		.acc             (acc)
	);

	mpid_mac u_mac (
		.clk      (clk),
		.ctl      (mac_ctl),
		.op_a     (op_a),
		.op_b     (op_b),
		.load_val (load_val),
		.acc      (acc)
	);

endmodule

>>> rtl/mpid_checker.sv
// port-level checks of the position pid controller and their binding
`include "assert_macros.svh"

module mpid_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              active,
	input logic signed [15:0] armature_steps,
	input logic signed [1:0] counter_nudge,
	input logic              voltage_limited,
	input logic              stalled
);

	// a held result stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

	// after an input transfer the block is busy in the following cycle
	`ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_valid && !in_stall, in_stall, "input taken on consecutive cycles")

	// a stall only follows voltage limiting and disables the drive
	`ASSERT_IMPL(a_stall_limited, clk, arst_n, out_valid && stalled, voltage_limited && !active, "stall without voltage limit")

	// unsynced result carries no steps, no nudge and no limit
	`ASSERT_IMPL(a_unsynced_quiet, clk, arst_n, out_valid && !active && !stalled, armature_steps == 16'sd0 && counter_nudge == 2'sd0 && !voltage_limited, "unsynced result not quiet")

	// nudge is -1, 0 or +1
	`ASSERT_IMPL(a_nudge_range, clk, arst_n, out_valid, counter_nudge != 2'b10, "nudge out of range")

endmodule

bind motor_position_pid_with_stall_detect mpid_checker u_mpid_checker (.*);

>>> verif/tb_top.sv
// self-checking testbench of the position pid controller with stall detection
`timescale 1ns / 100ps

module tb_top;

	localparam int     QUARTER_TURN  = 1024;
	localparam int     DITHER_FLOOR  = 50;
	localparam int     DRAIN_CYCLES  = 30;
	localparam int     HOLD_CYCLES   = 400;
	localparam longint SUM_MAX       = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_MIN       = -SUM_MAX - 1;
	localparam longint OVERVOLT_CAP  = 64'sh0000_0100_0000_0000;
	localparam longint VEL_MAX       = 64'sd2147483647;
	localparam longint VEL_MIN       = -64'sd2147483648;

	typedef struct {
		logic               synced;
		logic signed [23:0] count_delta;
		logic signed [31:0] pos_error;
		logic signed [15:0] lead_in;
		logic signed [31:0] velocity_in;
	} tick_in_t;

	typedef struct {
		logic               active;
		logic signed [15:0] armature_steps;
		logic [11:0]        drive_voltage;
		logic signed [15:0] lead_out;
		logic signed [31:0] velocity_out;
		logic signed [1:0]  counter_nudge;
		logic               voltage_limited;
		logic               stalled;
	} tick_out_t;

	class pid_scoreboard;
		longint    kp, ki, kd, v_limit, dither_step;
		longint    frac, err_sum, prev_err;
		bit        dither_phase;
		bit [11:0] prev_volt;
		tick_out_t pending_outputs[$];
		int        fails;

		function new();
			kp = 0;
			ki = 0;
			kd = 0;
			v_limit = 1024;
			dither_step = 0;
			frac = 0;
			err_sum = 0;
			prev_err = 0;
			dither_phase = 1'b0;
			prev_volt = '0;
			fails = 0;
		endfunction

		function void set_reg(mpid_pkg::reg_idx_t idx, logic [15:0] val);
			case (idx)
				mpid_pkg::REG_GAIN_P: kp = val;
				mpid_pkg::REG_GAIN_I: ki = val;
				mpid_pkg::REG_GAIN_D: kd = val;
				mpid_pkg::REG_STALL_V: v_limit = val[11:0];
				mpid_pkg::REG_ADAPT: dither_step = val[11:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_outputs.size();
		endfunction

		function longint integral();
			return err_sum;
		endfunction

		function void note_tick(tick_in_t t);
			tick_out_t r;
			longint    cnt, err, velo, s, steps, deriv, sh, sl, a, q, torque, mag, over, red;
			longint    drive, nudge;
			logic [15:0] lead;
			bit        limited, stall;
			cnt = t.count_delta;
			err = t.pos_error;
			velo = t.velocity_in;
			lead = t.lead_in;
			if (!t.synced) begin
				r.active = 1'b0;
				r.armature_steps = '0;
				r.drive_voltage = prev_volt;
				r.lead_out = t.lead_in;
				r.velocity_out = t.velocity_in;
				r.counter_nudge = '0;
				r.voltage_limited = 1'b0;
				r.stalled = 1'b0;
				pending_outputs.push_back(r);
				return;
			end
			// whole steps, half away from zero, excess kept in the fraction
			steps = 0;
			if (cnt != 0) begin
				s = frac + cnt;
				if (s >= 0)
					steps = (s + 128) / 256;
				else
					steps = -((-s + 128) / 256);
				if (steps > 32767)
					steps = 32767;
				if (steps < -32768)
					steps = -32768;
				frac = s - steps * 256;
			end
			err_sum = err_sum + err;
			if (err_sum > SUM_MAX)
				err_sum = SUM_MAX;
			if (err_sum < SUM_MIN)
				err_sum = SUM_MIN;
			deriv = err - prev_err;
			prev_err = err;
			nudge = 0;
			if (dither_step != 0 && prev_volt > DITHER_FLOOR) begin
				if (dither_phase) begin
					dither_phase = 1'b0;
					lead = 16'(lead - dither_step);
					if (deriv > 0)
						nudge = -1;
					else if (deriv < 0)
						nudge = 1;
				end else begin
					dither_phase = 1'b1;
					lead = 16'(lead + dither_step);
				end
			end
			// torque split so no product overflows, then truncated toward zero
			sh = err_sum >>> 16;
			sl = err_sum - sh * 65536;
			a = err * kp + deriv * kd + sl * ki;
			q = sh * ki + (a >>> 16);
			torque = q + ((q < 0 && a[15:0] != 16'd0) ? 1 : 0);
			mag = (torque < 0) ? -torque : torque;
			if (torque >= 0)
				lead = 16'(lead + QUARTER_TURN);
			else
				lead = 16'(lead - QUARTER_TURN);
			limited = 1'b0;
			stall = 1'b0;
			over = mag - v_limit;
			if (over > 0) begin
				limited = 1'b1;
				drive = v_limit;
				if (over > OVERVOLT_CAP)
					over = OVERVOLT_CAP;
				red = over * ki;
				if (torque >= 0) begin
					velo = velo - red;
					if (velo < VEL_MIN)
						velo = VEL_MIN;
					if (velo < 0)
						stall = 1'b1;
				end else begin
					velo = velo + red;
					if (velo > VEL_MAX)
						velo = VEL_MAX;
					if (velo > 0)
						stall = 1'b1;
				end
			end else begin
				drive = mag;
			end
			prev_volt = drive[11:0];
			r.active = !stall;
			r.armature_steps = steps[15:0];
			r.drive_voltage = prev_volt;
			r.lead_out = lead;
			r.velocity_out = velo[31:0];
			r.counter_nudge = nudge[1:0];
			r.voltage_limited = limited;
			r.stalled = stall;
			pending_outputs.push_back(r);
		endfunction

		function void compare_field(string field, logic signed [63:0] want,
				logic signed [63:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, actual %0d", field, want, got);
				fails++;
			end
		endfunction

		function void check_output(tick_out_t got);
			tick_out_t want;
			if (pending_outputs.size() == 0) begin
				$error("result transfer with no tick outstanding");
				fails++;
				return;
			end
			want = pending_outputs.pop_front();
			compare_field("active", want.active, got.active);
			compare_field("armature_steps", want.armature_steps, got.armature_steps);
			compare_field("drive_voltage", want.drive_voltage, got.drive_voltage);
			compare_field("lead_out", want.lead_out, got.lead_out);
			compare_field("velocity_out", want.velocity_out, got.velocity_out);
			compare_field("counter_nudge", want.counter_nudge, got.counter_nudge);
			compare_field("voltage_limited", want.voltage_limited, got.voltage_limited);
			compare_field("stalled", want.stalled, got.stalled);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	mpid_pkg::reg_idx_t wr_index = mpid_pkg::REG_GAIN_P;
	logic [15:0]        wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               synced = 1'b0;
	logic signed [23:0] count_delta = '0;
	logic signed [31:0] pos_error = '0;
	logic signed [15:0] lead_in = '0;
	logic signed [31:0] velocity_in = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               active;
	logic signed [15:0] armature_steps;
	logic [11:0]        drive_voltage;
	logic signed [15:0] lead_out;
	logic signed [31:0] velocity_out;
	logic signed [1:0]  counter_nudge;
	logic               voltage_limited;
	logic               stalled;

	pid_scoreboard sb;
	tick_out_t     observed;
	int            send_pct = 29;
	int            recv_pct = 29;
	int            hold_left = 0;
	bit            hold_req = 1'b0;
	bit            hold_ack = 1'b0;

	motor_position_pid_with_stall_detect #(
		.QUARTER_TURN(QUARTER_TURN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.synced(synced),
		.count_delta(count_delta),
		.pos_error(pos_error),
		.lead_in(lead_in),
		.velocity_in(velocity_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.active(active),
		.armature_steps(armature_steps),
		.drive_voltage(drive_voltage),
		.lead_out(lead_out),
		.velocity_out(velocity_out),
		.counter_nudge(counter_nudge),
		.voltage_limited(voltage_limited),
		.stalled(stalled)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("tb_top failed");
		$finish;
	end

	// result side: check each transfer, then choose the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			observed.active = active;
			observed.armature_steps = armature_steps;
			observed.drive_voltage = drive_voltage;
			observed.lead_out = lead_out;
			observed.velocity_out = velocity_out;
			observed.counter_nudge = counter_nudge;
			observed.voltage_limited = voltage_limited;
			observed.stalled = stalled;
			sb.check_output(observed);
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	task automatic write_reg(mpid_pkg::reg_idx_t idx, logic [15:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// upper bits of the narrow registers are filled with noise
	task automatic load_settings(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
			logic [11:0] vlim, logic [11:0] step);
		write_reg(mpid_pkg::REG_GAIN_P, kp);
		write_reg(mpid_pkg::REG_GAIN_I, ki);
		write_reg(mpid_pkg::REG_GAIN_D, kd);
		write_reg(mpid_pkg::REG_STALL_V, {4'($urandom), vlim});
		write_reg(mpid_pkg::REG_ADAPT, {4'($urandom), step});
		wr_en <= 1'b0;
	endtask

	task automatic send_tick(tick_in_t t);
		if ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		synced <= t.synced;
		count_delta <= t.count_delta;
		pos_error <= t.pos_error;
		lead_in <= t.lead_in;
		velocity_in <= t.velocity_in;
		do @(posedge clk); while (in_stall);
		sb.note_tick(t);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic tick_in_t mk_tick(logic s, logic signed [23:0] c,
			logic signed [31:0] e, logic signed [15:0] l, logic signed [31:0] v);
		tick_in_t t;
		t.synced = s;
		t.count_delta = c;
		t.pos_error = e;
		t.lead_in = l;
		t.velocity_in = v;
		return t;
	endfunction

	function automatic tick_in_t rand_tick();
		tick_in_t t;
		int       sel;
		t.synced = ($urandom_range(9) != 0);
		sel = $urandom_range(9);
		if (sel == 0)
			t.count_delta = '0;
		else if (sel < 5)
			t.count_delta = 24'($urandom_range(0, 2047) - 1024);
		else if (sel == 5) begin
			t.count_delta = 24'($urandom_range(0, 63) * 256 + 128);
			if ($urandom_range(1))
				t.count_delta = -t.count_delta;
		end else
			t.count_delta = 24'($urandom);
		sel = $urandom_range(9);
		if (sel < 4)
			t.pos_error = $urandom_range(0, 8191) - 4096;
		else if (sel < 7)
			t.pos_error = $signed($urandom) >>> 11;
		else if (sel < 9)
			t.pos_error = $urandom;
		else begin
			case ($urandom_range(3))
				0: t.pos_error = 32'sh7FFF_FFFF;
				1: t.pos_error = 32'sh8000_0000;
				2: t.pos_error = '0;
				default: t.pos_error = -32'sd1;
			endcase
		end
		t.lead_in = 16'($urandom);
		if ($urandom_range(1))
			t.velocity_in = $urandom;
		else
			t.velocity_in = $urandom_range(0, 131071) - 65536;
		return t;
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(4))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 1023));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [11:0] pick_volt();
		case ($urandom_range(4))
			0: return 12'd0;
			1: return 12'hFFF;
			2: return 12'(DITHER_FLOOR + $urandom_range(1));
			default: return 12'($urandom);
		endcase
	endfunction

	// integrator brought back to zero so later phases see moderate torque
	task automatic recentre_integral();
		tick_in_t t;
		longint   e;
		while (sb.integral() != 0) begin
			t = rand_tick();
			t.synced = 1'b1;
			e = -sb.integral();
			if (e > VEL_MAX)
				e = VEL_MAX;
			if (e < VEL_MIN)
				e = VEL_MIN;
			t.pos_error = e[31:0];
			send_tick(t);
		end
	endtask

	task automatic run_phase(int n, bit hold, bit pause);
		tick_in_t t;
		for (int i = 0; i < n; i++) begin
			if (hold && i == n / 3)
				hold_req <= ~hold_req;
			if (pause && i == n / 2) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (sb.pending() != 0);
			end
			t = rand_tick();
			send_tick(t);
		end
	endtask

	initial begin
		tick_in_t t;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_settings(16'd256, 16'd64, 16'd512, 12'd300, 12'd100);
		send_tick(mk_tick(1'b0, 24'sh80_0000, 32'sh7FFF_FFFF, 16'sh8000, 32'sh8000_0000));
		send_tick(mk_tick(1'b0, 24'sh7F_FFFF, 32'sh8000_0000, 16'sh7FFF, 32'sh7FFF_FFFF));
		send_tick(mk_tick(1'b1, 24'sd0, 32'sd0, 16'sd0, 32'sd0));
		send_tick(mk_tick(1'b1, 24'sd128, 32'sd256, 16'sh7FFF, 32'sd1000));
		send_tick(mk_tick(1'b1, -24'sd128, -32'sd256, 16'sh8000, -32'sd1000));
		send_tick(mk_tick(1'b1, -24'sd384, 32'sd1024, -16'sd1, 32'sd1));
		send_tick(mk_tick(1'b1, 24'sd127, 32'sd40000, 16'sd16384, 32'sd5000));
		send_tick(mk_tick(1'b1, -24'sd127, -32'sd40000, 16'sd0, -32'sd5000));
		send_tick(mk_tick(1'b1, 24'sd5, 32'sd10, 16'sd0, 32'sd0));
		send_tick(mk_tick(1'b1, 24'sh7F_FFFF, 32'sh7FFF_FFFF, 16'sd100, 32'sd100));
		send_tick(mk_tick(1'b1, 24'sh7F_FFFF, 32'sh7FFF_FFFF, 16'sd0, 32'sh7FFF_FFFF));
		send_tick(mk_tick(1'b1, 24'sh80_0000, 32'sh8000_0000, 16'sd0, -32'sd100));
		send_tick(mk_tick(1'b1, 24'sh80_0000, 32'sh8000_0000, 16'sd0, 32'sh8000_0000));
		send_tick(mk_tick(1'b1, 24'sh80_0000, 32'sh8000_0000, 16'sd0, 32'sh7FFF_FFFF));
		send_tick(mk_tick(1'b1, 24'sd1, 32'sh7FFF_FFFF, 16'sd0, 32'sh8000_0000));
		send_tick(mk_tick(1'b1, -24'sd1, 32'sd0, 16'sd0, 32'sd0));
		send_tick(mk_tick(1'b1, 24'sd0, 32'sd1, 16'sd0, 32'sd0));
		send_tick(mk_tick(1'b1, 24'sd0, -32'sd1, 16'sd0, 32'sd0));
		send_tick(mk_tick(1'b0, 24'sd0, 32'sd0, 16'sd0, 32'sd0));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: load_settings(16'd0, 16'd0, 16'd0, 12'd0, 12'hFFF);
				1: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
				default: load_settings(pick_gain(), pick_gain(), pick_gain(), pick_volt(),
						($urandom_range(3) == 0) ? 12'd0 : 12'($urandom));
			endcase
			send_pct = (ph == 4) ? 0 : 29;
			recv_pct = (ph == 4) ? 0 : 29;
			recentre_integral();
			run_phase(140, ph == 2, ph == 3);
			drain();
		end

		// sustained large error winds the integrator past the overvoltage cap
		load_settings(pick_gain(), 16'hFFFF, 16'($urandom_range(0, 255)), pick_volt(),
				12'($urandom));
		recentre_integral();
		for (int i = 0; i < 560; i++) begin
			t = rand_tick();
			t.synced = 1'b1;
			t.pos_error = 32'sh7FFF_FFFF - $urandom_range(0, 1 << 20);
			send_tick(t);
		end
		drain();

		if (sb.fails == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
